>>> sv/xcbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcbc_pkg: shared types and constants for the XTEA-CBC block decryptor
// Transaction payloads, key register indexes and the XTEA round constant.
// ----------------------------------------------------------------------------
package xcbc_pkg;

  localparam logic [31:0] XTEA_DELTA = 32'h9E37_79B9;

  localparam int WORD_W      = 32;
  localparam int CFG_INDEX_W = 8;

  localparam logic [CFG_INDEX_W-1:0] KEY_WORD0_IDX = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] KEY_WORD1_IDX = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] KEY_WORD2_IDX = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] KEY_WORD3_IDX = 8'd3;

  typedef logic [3:0][WORD_W-1:0] key_t;

  typedef struct packed {
    logic [WORD_W-1:0] cipher_first;
    logic [WORD_W-1:0] cipher_second;
    logic              last_block;
  } block_t;

  typedef struct packed {
    logic [WORD_W-1:0] plain_first;
    logic [WORD_W-1:0] plain_second;
    logic              ended_chain;
  } result_t;

endpackage

>>> sv/xcbc_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcbc_round: one XTEA decipher cycle
// Two Feistel half-rounds with the sum values of this cycle fixed at build.
// ----------------------------------------------------------------------------
module xcbc_round #(
  parameter logic [31:0] SUM_HI = 32'h0000_0000,
  parameter logic [31:0] SUM_LO = 32'h0000_0000
) (
  input  xcbc_pkg::key_t key,
  input  logic [31:0]    v0,
  input  logic [31:0]    v1,
  output logic [31:0]    v0_out,
  output logic [31:0]    v1_out
);

  function automatic logic [31:0] mix(input logic [31:0] v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

  logic [31:0] v1_next;

  assign v1_next = v1 - (mix(v0) ^ (SUM_HI + key[SUM_HI[12:11]]));
  assign v1_out  = v1_next;
  assign v0_out  = v0 - (mix(v1_next) ^ (SUM_LO + key[SUM_LO[1:0]]));

endmodule

>>> sv/xtea_cbc_block_decrypt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtea_cbc_block_decrypt: XTEA decipher of 64-bit blocks chained in CBC mode
// Key words 0 and 1 double as the IV at the start of each chain.
// ----------------------------------------------------------------------------
//  channel  | signals                          | role
//  block    | block_valid, block_stall, block  | ciphertext in
//  result   | result_valid, result_stall,      | plaintext out
//           | result                           |
//  cfg      | cfg_valid, cfg_ready, cfg_index, | key register writes
//           | cfg_data                         |
//
//  One block per cycle while block_stall is low: an input stage that latches
//  the block and its chaining word, then the unrolled rounds feeding the
//  result register. cfg_ready is always high.
//  Reset clears the keys and chaining state; the next block uses the IV.
//  A stalled result holds both stages; block_stall rises once both are full.
// ----------------------------------------------------------------------------
module xtea_cbc_block_decrypt #(
  parameter int ROUNDS = 2
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 block_valid,
  output logic                                 block_stall,
  input  xcbc_pkg::block_t                     block,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output xcbc_pkg::result_t                    result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [xcbc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [xcbc_pkg::WORD_W-1:0]          cfg_data
);

  xcbc_pkg::key_t   key;
  logic [63:0]      prev_cipher;
  logic             at_chain_start;

  logic             s1_valid;
  xcbc_pkg::block_t s1_block;
  logic [63:0]      s1_chain;

  logic             out_load;
  logic             s1_load;

  logic [ROUNDS:0][31:0] v0_chain;
  logic [ROUNDS:0][31:0] v1_chain;

  assign cfg_ready   = 1'b1;
  assign out_load    = !result_valid || !result_stall;
  assign block_stall = s1_valid && !out_load;
  assign s1_load     = block_valid && !block_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        xcbc_pkg::KEY_WORD0_IDX: key[0] <= cfg_data;
        xcbc_pkg::KEY_WORD1_IDX: key[1] <= cfg_data;
        xcbc_pkg::KEY_WORD2_IDX: key[2] <= cfg_data;
        xcbc_pkg::KEY_WORD3_IDX: key[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_cipher    <= '0;
      at_chain_start <= 1'b1;
      s1_valid       <= 1'b0;
    end else begin
      if (s1_load) begin
        prev_cipher    <= {block.cipher_second, block.cipher_first};
        at_chain_start <= block.last_block;
        s1_valid       <= 1'b1;
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_block <= block;
      s1_chain <= at_chain_start ? {key[1], key[0]} : prev_cipher;
    end
  end

  assign v0_chain[0] = s1_block.cipher_first;
  assign v1_chain[0] = s1_block.cipher_second;

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    localparam logic [63:0] SumHiWide = 64'(xcbc_pkg::XTEA_DELTA) * 64'(ROUNDS - r);
    localparam logic [63:0] SumLoWide = 64'(xcbc_pkg::XTEA_DELTA) * 64'(ROUNDS - r - 1);

    xcbc_round #(
      .SUM_HI (SumHiWide[31:0]),
      .SUM_LO (SumLoWide[31:0])
    ) u_round (
      .key    (key),
      .v0     (v0_chain[r]),
      .v1     (v1_chain[r]),
      .v0_out (v0_chain[r+1]),
      .v1_out (v1_chain[r+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      result.plain_first  <= v0_chain[ROUNDS] ^ s1_chain[31:0];
      result.plain_second <= v1_chain[ROUNDS] ^ s1_chain[63:32];
      result.ended_chain  <= s1_block.last_block;
    end
  end

endmodule

>>> sv/xcbc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcbc_checker: port-level checks for the XTEA-CBC block decryptor
// Latency, backpressure and result channel behavior seen at the ports.
// ----------------------------------------------------------------------------
module xcbc_checker (
  input logic              clk,
  input logic              rst,
  input logic              block_valid,
  input logic              block_stall,
  input logic              result_valid,
  input logic              result_stall,
  input xcbc_pkg::result_t result
);

  logic block_acc;

  assign block_acc = block_valid && !block_stall;

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result transaction dropped while stalled");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result))
    else $error("stalled result payload changed");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (block_acc ##1 (!result_valid || !result_stall)) |=> result_valid)
    else $error("accepted block did not reach the result register");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall && block_acc) ##1 result_stall |-> block_stall)
    else $error("block taken with both stages full");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

bind xtea_cbc_block_decrypt xcbc_checker u_xcbc_checker (
  .clk          (clk),
  .rst          (rst),
  .block_valid  (block_valid),
  .block_stall  (block_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
